// File: design/i2cbb_pkg.sv
`timescale 1ns / 1ps
package i2cbb_pkg;

  localparam int unsigned MaxBlockLen = 32;

  localparam logic [1:0] FuncTick  = 2'd0;
  localparam logic [1:0] FuncDesc  = 2'd1;
  localparam logic [1:0] FuncWrite = 2'd2;

  localparam logic CfgBusDelay = 1'b0;
  localparam logic CfgRetries  = 1'b1;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StAddrNak = 2'd1;
  localparam logic [1:0] StDataNak = 2'd2;
  localparam logic [1:0] StBadLen  = 2'd3;

  typedef enum logic [24:0] {
    PhIdle    = 25'd1 << 0,
    PhWaitMsg = 25'd1 << 1,
    PhWaitWr  = 25'd1 << 2,
    PhStA     = 25'd1 << 3,
    PhStB     = 25'd1 << 4,
    PhRsA     = 25'd1 << 5,
    PhRsB     = 25'd1 << 6,
    PhRsC     = 25'd1 << 7,
    PhRtA     = 25'd1 << 8,
    PhRtB     = 25'd1 << 9,
    PhRtC     = 25'd1 << 10,
    PhObA     = 25'd1 << 11,
    PhObB     = 25'd1 << 12,
    PhObC     = 25'd1 << 13,
    PhOkA     = 25'd1 << 14,
    PhOkB     = 25'd1 << 15,
    PhOkC     = 25'd1 << 16,
    PhIbA     = 25'd1 << 17,
    PhIbB     = 25'd1 << 18,
    PhAkA     = 25'd1 << 19,
    PhAkB     = 25'd1 << 20,
    PhAkC     = 25'd1 << 21,
    PhSpA     = 25'd1 << 22,
    PhSpB     = 25'd1 << 23,
    PhSpC     = 25'd1 << 24
  } phase_e;

  typedef struct packed {
    logic last;
    logic no_rd_ack;
    logic len_pre;
    logic rev;
    logic no_start;
    logic ign;
    logic ten;
    logic rd;
  } flags_t;

endpackage

// File: design/i2c_bitbang_master_top.sv
`timescale 1ns / 1ps
// Channel | handshake              | payload
// in      | in_valid_i / in_stall_o | func_i .. last_message_i
// out     | out_valid_o / out_stall_i | scl_out_o .. messages_done_o
// cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// One item per clock while the result is not stalled: the bus sequencer steps once per
// accepted item and the result word is registered in the same cycle.
// Reset puts the sequencer idle with both lines released and the bus delay and
// retry count at their defaults. A stalled result holds; the input is stalled only while a
// held result cannot be replaced.
module i2c_bitbang_master_top import i2cbb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic       sda_in_i,
  input  logic [9:0] value_i,
  input  logic       read_flag_i,
  input  logic       ten_bit_i,
  input  logic       ignore_nak_i,
  input  logic       no_start_i,
  input  logic       reverse_dir_i,
  input  logic       length_prefixed_i,
  input  logic       no_read_ack_i,
  input  logic [7:0] msg_length_i,
  input  logic       last_message_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_out_o,
  output logic       sda_out_o,
  output logic [7:0] read_data_o,
  output logic       read_valid_o,
  output logic       need_message_o,
  output logic       need_write_o,
  output logic       done_res_o,
  output logic [1:0] status_o,
  output logic [7:0] messages_done_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [9:0] cfg_data_i
);

  phase_e phase_q, phase_d;
  logic [3:0] bit_q, bit_d, att_q, att_d, retries_q;
  logic [7:0] shift_q, shift_d, mcount_q, mcount_d, abyte_q, abyte_d;
  logic [9:0] dly_q, dly_d, taddr_q, taddr_d, bus_delay_q;
  logic [8:0] left_q, left_d;
  flags_t     flags_q, flags_d;
  logic       first_q, first_d, scl_q, scl_d, sda_q, sda_d;
  logic [1:0] err_q, err_d, astage_q, astage_d;
  logic       inaddr_q, inaddr_d, gotf_q, gotf_d, ackdrv_q, ackdrv_d;
  logic [7:0] rdata;
  logic       rvalid, done;
  logic [9:0] full_w, half_w;
  logic [10:0] half_sum;
  logic [8:0] left_tmp;
  logic [7:0] sh_new;
  logic       acked, in_acc;

  assign in_stall_o  = out_valid_o && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign full_w      = bus_delay_q;
  assign half_sum    = {1'b0, bus_delay_q} + 11'd1;
  assign half_w      = half_sum[10:1];
  assign acked       = !sda_in_i;
  assign sh_new      = {shift_q[6:0], sda_in_i};

  always_comb begin
    phase_d = phase_q; bit_d = bit_q; att_d = att_q; shift_d = shift_q;
    mcount_d = mcount_q; abyte_d = abyte_q; dly_d = dly_q; taddr_d = taddr_q;
    left_d = left_q; flags_d = flags_q; first_d = first_q; scl_d = scl_q;
    sda_d = sda_q; err_d = err_q; astage_d = astage_q; inaddr_d = inaddr_q;
    gotf_d = gotf_q; ackdrv_d = ackdrv_q;
    rdata = '0; rvalid = 1'b0; done = 1'b0; left_tmp = '0;
    if (func_i == FuncDesc) begin
      if (phase_q == PhIdle || phase_q == PhWaitMsg) begin
        flags_d = '{last: last_message_i, no_rd_ack: no_read_ack_i,
                    len_pre: length_prefixed_i, rev: reverse_dir_i, no_start: no_start_i,
                    ign: ignore_nak_i, ten: ten_bit_i, rd: read_flag_i};
        taddr_d  = value_i;
        left_d   = {1'b0, msg_length_i};
        gotf_d   = 1'b0;
        att_d    = '0;
        astage_d = '0;
        inaddr_d = !no_start_i;
        if (ten_bit_i) abyte_d = 8'hf0 | {5'd0, value_i[9:8], 1'b0};
        else abyte_d = {value_i[6:0], read_flag_i ^ reverse_dir_i};
        if (first_q) begin
          first_d = 1'b0; mcount_d = '0; err_d = StOk; phase_d = PhStA;
        end else if (!no_start_i) begin
          phase_d = PhRsA;
        end else if (msg_length_i == 8'd0) begin
          if (mcount_q != 8'hff) mcount_d = mcount_q + 8'd1;
          phase_d = last_message_i ? PhSpA : PhWaitMsg;
        end else if (read_flag_i) begin
          bit_d = '0; shift_d = '0; phase_d = PhIbA;
        end else begin
          phase_d = PhWaitWr;
        end
      end
    end else if (func_i == FuncWrite) begin
      if (phase_q == PhWaitWr) begin
        inaddr_d = 1'b0; shift_d = value_i[7:0]; bit_d = 4'd7; phase_d = PhObA;
      end
    end else if (func_i == FuncTick) begin
      if (dly_q != '0) begin
        dly_d = dly_q - 10'd1;
      end else begin
        // begin_data target, reused by several phases below
        unique case (phase_q)
          PhStA: begin sda_d = 1'b0; dly_d = full_w; phase_d = PhStB; end
          PhStB, PhRsC: begin
            scl_d = 1'b0;
            if (inaddr_q) begin
              shift_d = abyte_q; bit_d = 4'd7; phase_d = PhObA;
            end else begin
              phase_d = PhWaitMsg; // overwritten by data start
              if (left_q == '0) begin
                if (mcount_q != 8'hff) mcount_d = mcount_q + 8'd1;
                phase_d = flags_q.last ? PhSpA : PhWaitMsg;
              end else if (flags_q.rd) begin
                bit_d = '0; shift_d = '0; phase_d = PhIbA;
              end else phase_d = PhWaitWr;
            end
          end
          PhRsA: begin sda_d = 1'b1; scl_d = 1'b1; dly_d = full_w; phase_d = PhRsB; end
          PhRsB: begin sda_d = 1'b0; dly_d = full_w; phase_d = PhRsC; end
          PhRtA: begin sda_d = 1'b0; scl_d = 1'b1; dly_d = full_w; phase_d = PhRtB; end
          PhRtB: begin sda_d = 1'b1; dly_d = full_w; phase_d = PhRtC; end
          PhRtC: begin dly_d = full_w; phase_d = PhStA; end
          PhObA: begin sda_d = shift_q[bit_q[2:0]]; dly_d = half_w; phase_d = PhObB; end
          PhObB: begin scl_d = 1'b1; dly_d = half_w; phase_d = PhObC; end
          PhObC: begin
            scl_d = 1'b0;
            if (bit_q == '0) phase_d = PhOkA;
            else begin bit_d = bit_q - 4'd1; phase_d = PhObA; end
          end
          PhOkA: begin sda_d = 1'b1; dly_d = half_w; phase_d = PhOkB; end
          PhOkB: begin scl_d = 1'b1; dly_d = half_w; phase_d = PhOkC; end
          PhOkC: begin
            scl_d = 1'b0;
            if (!inaddr_q) begin
              if (acked || flags_q.ign) begin
                left_tmp = (left_q != '0) ? left_q - 9'd1 : left_q;
                left_d = left_tmp;
                inaddr_d = 1'b0;
                if (left_tmp == '0) begin
                  if (mcount_q != 8'hff) mcount_d = mcount_q + 8'd1;
                  phase_d = flags_q.last ? PhSpA : PhWaitMsg;
                end else if (flags_q.rd) begin
                  bit_d = '0; shift_d = '0; phase_d = PhIbA;
                end else phase_d = PhWaitWr;
              end else begin
                err_d = StDataNak; phase_d = PhSpA;
              end
            end else if (astage_q != 2'd1 && !acked &&
                         att_q < (flags_q.ign ? 4'd0 : retries_q)) begin
              att_d = att_q + 4'd1; phase_d = PhRtA;
            end else if (!acked && !flags_q.ign) begin
              err_d = StAddrNak; phase_d = PhSpA;
            end else if (astage_q == 2'd0 && flags_q.ten) begin
              astage_d = 2'd1; shift_d = taddr_q[7:0]; bit_d = 4'd7; phase_d = PhObA;
            end else if (astage_q == 2'd1 && flags_q.rd) begin
              astage_d = 2'd2; abyte_d = abyte_q | 8'h01; att_d = '0; phase_d = PhRsA;
            end else begin
              inaddr_d = 1'b0;
              if (left_q == '0) begin
                if (mcount_q != 8'hff) mcount_d = mcount_q + 8'd1;
                phase_d = flags_q.last ? PhSpA : PhWaitMsg;
              end else if (flags_q.rd) begin
                bit_d = '0; shift_d = '0; phase_d = PhIbA;
              end else phase_d = PhWaitWr;
            end
          end
          PhIbA: begin sda_d = 1'b1; scl_d = 1'b1; dly_d = half_w; phase_d = PhIbB; end
          PhIbB: begin
            shift_d = sh_new;
            scl_d = 1'b0;
            if (bit_q < 4'd7) begin
              bit_d = bit_q + 4'd1; dly_d = full_w; phase_d = PhIbA;
            end else begin
              dly_d = {1'b0, full_w[9:1]};
              rdata = sh_new; rvalid = 1'b1;
              left_tmp = (left_q != '0) ? left_q - 9'd1 : left_q;
              left_d = left_tmp;
              gotf_d = 1'b1;
              if (!gotf_q && flags_q.len_pre &&
                  (sh_new == 8'd0 || sh_new > 8'(MaxBlockLen))) begin
                err_d = StBadLen;
                if (flags_q.no_rd_ack) phase_d = PhSpA;
                else begin ackdrv_d = 1'b1; phase_d = PhAkA; end
              end else begin
                if (!gotf_q && flags_q.len_pre) left_tmp = left_tmp + {1'b0, sh_new};
                left_d = left_tmp;
                if (flags_q.no_rd_ack) begin
                  inaddr_d = 1'b0;
                  if (left_tmp == '0) begin
                    if (mcount_q != 8'hff) mcount_d = mcount_q + 8'd1;
                    phase_d = flags_q.last ? PhSpA : PhWaitMsg;
                  end else begin
                    bit_d = '0; shift_d = '0; phase_d = PhIbA;
                  end
                end else begin
                  ackdrv_d = (left_tmp == '0); phase_d = PhAkA;
                end
              end
            end
          end
          PhAkA: begin sda_d = ackdrv_q; dly_d = half_w; phase_d = PhAkB; end
          PhAkB: begin scl_d = 1'b1; dly_d = half_w; phase_d = PhAkC; end
          PhAkC: begin
            scl_d = 1'b0;
            if (err_q != StOk) phase_d = PhSpA;
            else begin
              inaddr_d = 1'b0;
              if (left_q == '0) begin
                if (mcount_q != 8'hff) mcount_d = mcount_q + 8'd1;
                phase_d = flags_q.last ? PhSpA : PhWaitMsg;
              end else if (flags_q.rd) begin
                bit_d = '0; shift_d = '0; phase_d = PhIbA;
              end else phase_d = PhWaitWr;
            end
          end
          PhSpA: begin sda_d = 1'b0; scl_d = 1'b1; dly_d = full_w; phase_d = PhSpB; end
          PhSpB: begin sda_d = 1'b1; dly_d = full_w; phase_d = PhSpC; end
          PhSpC: begin done = 1'b1; phase_d = PhIdle; first_d = 1'b1; end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle; bit_q <= '0; att_q <= '0; shift_q <= '0; mcount_q <= '0;
      abyte_q <= '0; dly_q <= '0; taddr_q <= '0; left_q <= '0; flags_q <= '0;
      first_q <= 1'b1; scl_q <= 1'b1; sda_q <= 1'b1; err_q <= StOk; astage_q <= '0;
      inaddr_q <= 1'b0; gotf_q <= 1'b0; ackdrv_q <= 1'b0;
      bus_delay_q <= 10'd5; retries_q <= 4'd3; out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgBusDelay) bus_delay_q <= cfg_data_i;
        else retries_q <= cfg_data_i[3:0];
      end
      if (in_acc) begin
        phase_q <= phase_d; bit_q <= bit_d; att_q <= att_d; shift_q <= shift_d;
        mcount_q <= mcount_d; abyte_q <= abyte_d; dly_q <= dly_d; taddr_q <= taddr_d;
        left_q <= left_d; flags_q <= flags_d; first_q <= first_d; scl_q <= scl_d;
        sda_q <= sda_d; err_q <= err_d; astage_q <= astage_d; inaddr_q <= inaddr_d;
        gotf_q <= gotf_d; ackdrv_q <= ackdrv_d;
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // result word; loads only with an accepted item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      scl_out_o       <= scl_d;
      sda_out_o       <= sda_d;
      read_data_o     <= rdata;
      read_valid_o    <= rvalid;
      need_message_o  <= (phase_d == PhIdle) || (phase_d == PhWaitMsg);
      need_write_o    <= (phase_d == PhWaitWr);
      done_res_o      <= done;
      status_o        <= done ? err_q : StOk;
      messages_done_o <= done ? mcount_q : 8'd0;
    end
  end

endmodule

// File: design/i2cbb_checker.sv
`timescale 1ns / 1ps
module i2cbb_checker import i2cbb_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       read_valid_o,
  input logic       done_res_o,
  input logic       need_message_o,
  input logic       need_write_o,
  input logic [1:0] status_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");

  a_acc_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o) else $error("no result");

  a_need_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(need_message_o && need_write_o)) else $error("two waits");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> need_message_o && !read_valid_o)
    else $error("done not idle");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> status_o == StOk) else $error("stray status");

endmodule

bind i2c_bitbang_master_top i2cbb_checker u_chk (.*);

// File: bench/i2c_bitbang_master_top_test.sv
`timescale 1ns / 1ps
module i2c_bitbang_master_top_test;
  import i2cbb_pkg::*;

  typedef struct {
    logic [1:0] func;
    logic       sda;
    logic [9:0] value;
    flags_t     fl;
    logic [7:0] len;
  } bus_item_t;

  typedef struct {
    logic       scl;
    logic       sda;
    logic [7:0] rdata;
    logic       rvalid;
    logic       need_msg;
    logic       need_wr;
    logic       done;
    logic [1:0] status;
    logic [7:0] mdone;
  } bus_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] func_i = FuncTick;
  logic       sda_in_i = 1'b1;
  logic [9:0] value_i = '0;
  flags_t     flags_i = '0;
  logic [7:0] msg_length_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       scl_out_o, sda_out_o, read_valid_o, need_message_o, need_write_o, done_res_o;
  logic [7:0] read_data_o, messages_done_o;
  logic [1:0] status_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = CfgBusDelay;
  logic [9:0] cfg_data_i = '0;

  i2c_bitbang_master_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .sda_in_i, .value_i,
    .read_flag_i(flags_i.rd), .ten_bit_i(flags_i.ten), .ignore_nak_i(flags_i.ign),
    .no_start_i(flags_i.no_start), .reverse_dir_i(flags_i.rev),
    .length_prefixed_i(flags_i.len_pre), .no_read_ack_i(flags_i.no_rd_ack),
    .msg_length_i, .last_message_i(flags_i.last), .out_valid_o, .out_stall_i,
    .scl_out_o, .sda_out_o, .read_data_o, .read_valid_o, .need_message_o, .need_write_o,
    .done_res_o, .status_o, .messages_done_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i,
    .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // bus model state
  logic [9:0] bus_delay;
  logic [3:0] addr_retries;
  phase_e     ph;
  logic [3:0] bit_idx, tries;
  logic [7:0] shreg, msg_cnt, abyte;
  logic [9:0] dly, taddr;
  logic [8:0] left;
  flags_t     mfl;
  logic       first_msg, scl_d, sda_d, ack_d, in_addr, got_first;
  logic [1:0] err, astage;
  logic       xfer_done;

  bus_word_t  words_due[$];
  bus_item_t  desc_q[$];
  int         errors = 0;
  bit         quiet = 1'b0;
  int         stall_left = 0;
  int         nak_pct = 10;
  int         force_len = -1;
  int         item_cnt = 0;

  function automatic logic [9:0] half_delay();
    return 10'((11'(bus_delay) + 11'd1) >> 1);
  endfunction

  function automatic void load_byte(logic [7:0] b);
    shreg = b;
    bit_idx = 4'd7;
    ph = PhObA;
  endfunction

  function automatic void end_message();
    if (msg_cnt != 8'd255) msg_cnt++;
    ph = mfl.last ? PhSpA : PhWaitMsg;
  endfunction

  function automatic void start_data();
    in_addr = 1'b0;
    if (left == 0) begin
      end_message();
    end else if (mfl.rd) begin
      bit_idx = '0;
      shreg = '0;
      ph = PhIbA;
    end else begin
      ph = PhWaitWr;
    end
  endfunction

  function automatic void after_start();
    scl_d = 1'b0;
    if (in_addr) load_byte(abyte);
    else start_data();
  endfunction

  function automatic void take_desc(bus_item_t it);
    mfl = it.fl;
    taddr = it.value;
    left = {1'b0, it.len};
    got_first = 1'b0;
    tries = '0;
    astage = '0;
    in_addr = !mfl.no_start;
    if (mfl.ten) begin
      abyte = 8'hf0 | ({5'd0, taddr[9:7]} & 8'h06);
    end else begin
      abyte = {taddr[6:0], mfl.rd};
      if (mfl.rev) abyte[0] = ~abyte[0];
    end
    if (first_msg) begin
      first_msg = 1'b0;
      msg_cnt = '0;
      err = StOk;
      ph = PhStA;
    end else if (in_addr) begin
      ph = PhRsA;
    end else begin
      start_data();
    end
  endfunction

  function automatic void ack_seen(logic acked);
    logic [3:0] limit;
    if (!in_addr) begin
      if (acked || mfl.ign) begin
        if (left != 0) left--;
        start_data();
      end else begin
        err = StDataNak;
        ph = PhSpA;
      end
      return;
    end
    if (astage != 2'd1) begin
      limit = mfl.ign ? 4'd0 : addr_retries;
      if (!acked && tries < limit) begin
        tries++;
        ph = PhRtA;
        return;
      end
    end
    if (!acked && !mfl.ign) begin
      err = StAddrNak;
      ph = PhSpA;
    end else if (astage == 2'd0 && mfl.ten) begin
      astage = 2'd1;
      load_byte(taddr[7:0]);
    end else if (astage == 2'd1 && mfl.rd) begin
      astage = 2'd2;
      abyte[0] = 1'b1;
      tries = '0;
      ph = PhRsA;
    end else begin
      start_data();
    end
  endfunction

  function automatic void bus_tick(logic sda, inout bus_word_t r);
    logic bad;
    if (dly != 0) begin
      dly--;
      return;
    end
    case (ph)
      PhStA: begin sda_d = 0; dly = bus_delay; ph = PhStB; end
      PhStB: after_start();
      PhRsA: begin sda_d = 1; scl_d = 1; dly = bus_delay; ph = PhRsB; end
      PhRsB: begin sda_d = 0; dly = bus_delay; ph = PhRsC; end
      PhRsC: after_start();
      PhRtA: begin sda_d = 0; scl_d = 1; dly = bus_delay; ph = PhRtB; end
      PhRtB: begin sda_d = 1; dly = bus_delay; ph = PhRtC; end
      PhRtC: begin dly = bus_delay; ph = PhStA; end
      PhObA: begin sda_d = shreg[bit_idx[2:0]]; dly = half_delay(); ph = PhObB; end
      PhObB: begin scl_d = 1; dly = half_delay(); ph = PhObC; end
      PhObC: begin
        scl_d = 0;
        if (bit_idx == 0) ph = PhOkA;
        else begin bit_idx--; ph = PhObA; end
      end
      PhOkA: begin sda_d = 1; dly = half_delay(); ph = PhOkB; end
      PhOkB: begin scl_d = 1; dly = half_delay(); ph = PhOkC; end
      PhOkC: begin scl_d = 0; ack_seen(sda == 1'b0); end
      PhIbA: begin sda_d = 1; scl_d = 1; dly = half_delay(); ph = PhIbB; end
      PhIbB: begin
        shreg = {shreg[6:0], sda};
        scl_d = 0;
        if (bit_idx < 7) begin
          bit_idx++;
          dly = bus_delay;
          ph = PhIbA;
        end else begin
          bad = 1'b0;
          dly = bus_delay >> 1;
          r.rdata = shreg;
          r.rvalid = 1'b1;
          if (left != 0) left--;
          if (!got_first && mfl.len_pre) begin
            got_first = 1'b1;
            if (shreg == 0 || shreg > MaxBlockLen) begin
              bad = 1'b1;
              err = StBadLen;
              if (mfl.no_rd_ack) ph = PhSpA;
              else begin ack_d = 1; ph = PhAkA; end
            end else begin
              left = left + {1'b0, shreg};
            end
          end
          if (!bad) begin
            got_first = 1'b1;
            if (mfl.no_rd_ack) start_data();
            else begin ack_d = (left == 0); ph = PhAkA; end
          end
        end
      end
      PhAkA: begin sda_d = ack_d; dly = half_delay(); ph = PhAkB; end
      PhAkB: begin scl_d = 1; dly = half_delay(); ph = PhAkC; end
      PhAkC: begin
        scl_d = 0;
        if (err != StOk) ph = PhSpA;
        else start_data();
      end
      PhSpA: begin sda_d = 0; scl_d = 1; dly = bus_delay; ph = PhSpB; end
      PhSpB: begin sda_d = 1; dly = bus_delay; ph = PhSpC; end
      PhSpC: begin
        r.done = 1'b1;
        r.status = err;
        r.mdone = msg_cnt;
        ph = PhIdle;
        first_msg = 1'b1;
        xfer_done = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic bus_word_t step_bus(bus_item_t it);
    bus_word_t r;
    r = '{default: '0};
    case (it.func)
      FuncDesc: if (ph == PhIdle || ph == PhWaitMsg) take_desc(it);
      FuncWrite: if (ph == PhWaitWr) begin
        in_addr = 1'b0;
        load_byte(it.value[7:0]);
      end
      FuncTick: bus_tick(it.sda, r);
      default: ;
    endcase
    r.scl = scl_d;
    r.sda = sda_d;
    r.need_msg = (ph == PhIdle || ph == PhWaitMsg);
    r.need_wr = (ph == PhWaitWr);
    return r;
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin
    bus_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (words_due.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        e = words_due.pop_front();
        if (scl_out_o !== e.scl) report($sformatf("scl_out %b want %b", scl_out_o, e.scl));
        if (sda_out_o !== e.sda) report($sformatf("sda_out %b want %b", sda_out_o, e.sda));
        if (read_data_o !== e.rdata)
          report($sformatf("read_data %h want %h", read_data_o, e.rdata));
        if (read_valid_o !== e.rvalid)
          report($sformatf("read_valid %b want %b", read_valid_o, e.rvalid));
        if (need_message_o !== e.need_msg)
          report($sformatf("need_message %b want %b", need_message_o, e.need_msg));
        if (need_write_o !== e.need_wr)
          report($sformatf("need_write %b want %b", need_write_o, e.need_wr));
        if (done_res_o !== e.done) report($sformatf("done_res %b want %b", done_res_o, e.done));
        if (status_o !== e.status) report($sformatf("status %0d want %0d", status_o, e.status));
        if (messages_done_o !== e.mdone)
          report($sformatf("messages_done %0d want %0d", messages_done_o, e.mdone));
      end
    end
  end

  // receiver back-pressure in bursts
  always @(posedge clk_i) begin
    if (quiet || !rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_item(bus_item_t it);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= it.func;
    sda_in_i <= it.sda;
    value_i <= it.value;
    flags_i <= it.fl;
    msg_length_i <= it.len;
    do @(posedge clk_i); while (in_stall_o);
    words_due.push_back(step_bus(it));
  endtask

  task automatic drain_words();
    in_valid_i <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [9:0] data);
    drain_words();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgBusDelay) bus_delay = data;
    else addr_retries = data[3:0];
  endtask

  function automatic bus_item_t tick_item(logic sda);
    bus_item_t it;
    it = '{func: FuncTick, sda: sda, value: 10'($urandom), fl: flags_t'($urandom),
           len: 8'($urandom)};
    return it;
  endfunction

  function automatic bus_item_t desc_item(logic [9:0] v, flags_t f, logic [7:0] n);
    bus_item_t it;
    it = '{func: FuncDesc, sda: 1'($urandom), value: v, fl: f, len: n};
    return it;
  endfunction

  function automatic bus_item_t rand_desc(logic last);
    flags_t f;
    logic [7:0] n;
    f = flags_t'($urandom);
    f.ten = ($urandom_range(0, 9) < 3);
    f.no_start = ($urandom_range(0, 9) < 2);
    f.len_pre = f.rd && ($urandom_range(0, 9) < 3);
    f.no_rd_ack = ($urandom_range(0, 9) < 2);
    f.last = last;
    case ($urandom_range(0, 49))
      0: n = 8'($urandom_range(17, 255));
      1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: n = 8'($urandom_range(4, 16));
      default: n = 8'($urandom_range(0, 3));
    endcase
    return desc_item(10'($urandom), f, n);
  endfunction

  // pick the sda level the device would present in the current bit
  function automatic logic device_sda();
    if (ph == PhOkB || ph == PhOkC) return ($urandom_range(0, 99) < nak_pct);
    if ((ph == PhIbA || ph == PhIbB) && force_len >= 0 && !got_first && mfl.len_pre)
      return force_len[7 - bit_idx[2:0]];
    return 1'($urandom);
  endfunction

  // feed the bus until the stop completes; descriptors come from desc_q, or are random once it is empty
  task automatic run_transfer(bit noisy);
    bus_item_t it;
    xfer_done = 1'b0;
    while (!xfer_done) begin
      if (noisy && $urandom_range(0, 24) == 0) begin
        it = tick_item(1'($urandom));
        it.value = 10'($urandom);
        if (ph == PhIdle || ph == PhWaitMsg) it.func = $urandom_range(0, 1) ? FuncWrite : 2'd3;
        else if (ph == PhWaitWr) it.func = $urandom_range(0, 1) ? FuncDesc : 2'd3;
        else it.func = 2'($urandom_range(1, 3));
        send_item(it);
        continue;
      end
      if (ph == PhIdle || ph == PhWaitMsg) begin
        it = (desc_q.size() != 0) ? desc_q.pop_front() : rand_desc(1'b1);
      end else if (ph == PhWaitWr) begin
        it = tick_item(1'($urandom));
        it.func = FuncWrite;
      end else begin
        it = tick_item(device_sda());
      end
      send_item(it);
      item_cnt++;
    end
    desc_q.delete();
  endtask

  task automatic test_misplaced_items();
    bus_item_t it;
    it = tick_item(1'b0);
    it.func = FuncWrite;
    send_item(it);
    it.func = 2'd3;
    send_item(it);
    send_item(tick_item(1'b1));
    send_item(tick_item(1'b0));
    drain_words();
  endtask

  task automatic test_seven_bit_write();
    nak_pct = 0;
    desc_q.push_back(desc_item(10'h3ff, '{rev: 1'b1, default: 1'b0}, 8'd0));
    desc_q.push_back(desc_item(10'h000, '{no_start: 1'b1, last: 1'b1, default: 1'b0}, 8'd1));
    run_transfer(1'b0);
    drain_words();
  endtask

  task automatic test_ten_bit_read();
    write_reg(CfgBusDelay, 10'd0);
    nak_pct = 0;
    desc_q.push_back(desc_item(10'h2a5, '{ten: 1'b1, rd: 1'b1, default: 1'b0}, 8'd0));
    desc_q.push_back(desc_item(10'h1ff,
                     '{ten: 1'b1, no_rd_ack: 1'b1, rd: 1'b1, last: 1'b1, default: 1'b0}, 8'd1));
    run_transfer(1'b0);
    drain_words();
  endtask

  task automatic test_address_nak();
    write_reg(CfgRetries, 10'd1);
    nak_pct = 100;
    desc_q.push_back(desc_item(10'h012, '{last: 1'b1, default: 1'b0}, 8'd1));
    run_transfer(1'b0);
    // ignored naks push on through address and data
    desc_q.push_back(desc_item(10'h012, '{ign: 1'b1, default: 1'b0}, 8'd0));
    desc_q.push_back(desc_item(10'h013, '{ign: 1'b1, ten: 1'b1, rd: 1'b1, last: 1'b1,
                                          default: 1'b0}, 8'd1));
    run_transfer(1'b0);
    write_reg(CfgRetries, 10'd0);
    desc_q.push_back(desc_item(10'h012, '{last: 1'b1, default: 1'b0}, 8'd1));
    run_transfer(1'b0);
    drain_words();
  endtask

  task automatic test_block_read();
    int lens[3] = '{0, 33, 2};
    nak_pct = 0;
    foreach (lens[k]) begin
      force_len = lens[k];
      desc_q.push_back(desc_item(10'h050, '{len_pre: 1'b1, rd: 1'b1, last: 1'b1,
                                            no_rd_ack: k[0], default: 1'b0}, 8'd1));
      run_transfer(1'b0);
    end
    force_len = -1;
    drain_words();
  endtask

  task automatic test_count_saturation();
    nak_pct = 0;
    for (int k = 0; k < 259; k++)
      desc_q.push_back(desc_item(10'h020, '{no_start: 1'b1, default: 1'b0}, 8'd0));
    desc_q.push_back(desc_item(10'h020, '{no_start: 1'b1, last: 1'b1, default: 1'b0}, 8'd0));
    run_transfer(1'b0);
    drain_words();
  endtask

  task automatic test_slow_bus();
    write_reg(CfgBusDelay, 10'd11);
    nak_pct = 0;
    desc_q.push_back(desc_item(10'h041, '{no_start: 1'b1, last: 1'b1, default: 1'b0}, 8'd0));
    run_transfer(1'b0);
    drain_words();
  endtask

  task automatic test_random();
    int n;
    while (item_cnt < 1250) begin
      case ($urandom_range(0, 7))
        0: write_reg(CfgBusDelay, 10'd0);
        1: write_reg(CfgBusDelay, 10'($urandom_range(1, 6)));
        2: write_reg(CfgRetries, 10'($urandom));
        default: ;
      endcase
      nak_pct = $urandom_range(0, 3) == 0 ? 40 : 5;
      force_len = $urandom_range(0, 1) ? $urandom_range(0, 40) : -1;
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) desc_q.push_back(rand_desc(k == n - 1));
      quiet = (item_cnt > 1200);
      run_transfer(1'b1);
    end
    drain_words();
  endtask

  initial begin
    bus_delay = 10'd5;
    addr_retries = 4'd3;
    ph = PhIdle;
    {bit_idx, shreg, dly, tries, left, taddr, msg_cnt} = '0;
    mfl = '0;
    first_msg = 1'b1;
    err = StOk;
    {scl_d, sda_d} = 2'b11;
    {abyte, astage, ack_d, in_addr, got_first} = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_misplaced_items();
    test_seven_bit_write();
    test_ten_bit_read();
    test_address_nak();
    test_block_read();
    test_count_saturation();
    test_slow_bus();
    test_random();
    if (words_due.size() != 0) report("expected words left over");
    if (errors == 0) begin
      $display("** i2c_bitbang_master_top: PASSED **");
    end else begin
      $display("** i2c_bitbang_master_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("** i2c_bitbang_master_top: FAILED **");
    $finish;
  end

endmodule
